[hdl/tcce_pkg.sv]
package tcce_pkg;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CUR,
		ST_PB,
		ST_AB,
		ST_RC_RD,
		ST_RC_GOT,
		ST_TT_RD,
		ST_TT_WR,
		ST_RW_RD,
		ST_RW_WR,
		ST_SC_RD,
		ST_SC_WR,
		ST_CURWR,
		ST_ACTRD,
		ST_ACT
	} tcce_state_t;

	localparam logic [2:0] MODE_SET_CURSOR  = 3'd0;
	localparam logic [2:0] MODE_READ_CURSOR = 3'd1;
	localparam logic [2:0] MODE_SELECT_PAGE = 3'd2;
	localparam logic [2:0] MODE_SCROLL_UP   = 3'd3;
	localparam logic [2:0] MODE_SCROLL_DOWN = 3'd4;
	localparam logic [2:0] MODE_READ_CELL   = 3'd5;
	localparam logic [2:0] MODE_REPEAT      = 3'd6;
	localparam logic [2:0] MODE_TELETYPE    = 3'd7;

	localparam logic [7:0] CH_BEL   = 8'h07;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [7:0]  RESET_ATTR = 8'h0f;
	localparam logic [15:0] BLANK_CELL = {RESET_ATTR, CH_SPACE};

endpackage

[hdl/tcce_ram.sv]
module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[hdl/text_console_cell_engine.sv]
// channel   | ports                                              | handshake
// request   | mode page row column character attribute count    | start && !busy
//           | write_attribute top left bottom right              |
// result    | cursor_row cursor_column read_character            | done, one cycle
//           | read_attribute active_page active_row active_column|
// busy covers only the request itself for cursor and page requests, empty scrolls and
//   teletype controls; read cell and teletype add a cell read, repeat write a read and a write
//   per cell, scroll per window cell; teletype also scrolls the page when it reaches the bottom
// the single-port cell memory, one access a cycle, sets the per-cell cost
// after reset a clearing pass over all PAGES*ROWS*COLUMNS cells holds busy high
// done is a strobe in the same cycle that busy falls; the receiver cannot stall
module text_console_cell_engine #(
	parameter int PAGES   = 8,
	parameter int ROWS    = 25,
	parameter int COLUMNS = 80
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output logic       done,
	input  logic [2:0] mode,
	input  logic [2:0] page,
	input  logic [4:0] row,
	input  logic [6:0] column,
	input  logic [7:0] character,
	input  logic [7:0] attribute,
	input  logic [15:0] count,
	input  logic       write_attribute,
	input  logic [4:0] top,
	input  logic [6:0] left,
	input  logic [4:0] bottom,
	input  logic [6:0] right,
	output logic [4:0] cursor_row,
	output logic [6:0] cursor_column,
	output logic [7:0] read_character,
	output logic [7:0] read_attribute,
	output logic [2:0] active_page,
	output logic [4:0] active_row,
	output logic [6:0] active_column
);

	localparam int CPP   = ROWS * COLUMNS;
	localparam int CELLS = PAGES * CPP;
	localparam int AW    = $clog2(CELLS);
	localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int HW    = $clog2(ROWS + 1);
	localparam int XW    = HW + 1;
	localparam int PSW   = $clog2(CPP);

	tcce_pkg::tcce_state_t state_q, state_d;

	logic [AW-1:0]     clr_q;
	logic [PGW-1:0]    shown_q;
	logic              done_q;

	logic [2:0]        mode_q;
	logic [PGW-1:0]    pg_q;
	logic [PGW-1:0]    sp_q;
	logic [RW-1:0]     row_q;
	logic [CW-1:0]     col_q;
	logic [7:0]        ch_q;
	logic [7:0]        attr_q;
	logic [15:0]       rem_q;
	logic              wattr_q;
	logic [RW-1:0]     cur_r_q;
	logic [CW-1:0]     cur_c_q;
	logic [7:0]        rdch_q;
	logic [7:0]        rdattr_q;

	logic [RW-1:0]     sc_t_q, sc_b_q, sr_q;
	logic [CW-1:0]     sc_l_q, sc_r_q, sc_c_q;
	logic [HW-1:0]     n_q;
	logic [7:0]        sc_attr_q;
	logic              sc_up_q;
	logic              sc_job_q;

	logic [AW-1:0]     pbase_q, rowoff_q, noff_q, addr_q, dbase_q, sbase_q;
	logic [PSW-1:0]    pos_q;

	logic [4:0]        o_row_q, o_arow_q;
	logic [6:0]        o_col_q, o_acol_q;
	logic [7:0]        o_ch_q, o_attr_q;
	logic [2:0]        o_page_q;

	logic              cell_we;
	logic [AW-1:0]     cell_addr;
	logic [15:0]       cell_wdata, cell_rdata;
	logic              cur_we;
	logic [PGW-1:0]    cur_addr;
	logic [RW+CW-1:0]  cur_wdata, cur_rdata;
	logic [RW-1:0]     crd_r;
	logic [CW-1:0]     crd_c;

	logic [PGW-1:0]    pg_in;
	logic [RW-1:0]     row_in, top_in, bot_in;
	logic [CW-1:0]     col_in, left_in, right_in;
	logic [XW-1:0]     height;
	logic [RW-1:0]     rowsel;
	logic              blank, col_end, row_end;
	logic              win_empty;

	assign crd_r = cur_rdata[RW+CW-1:CW];
	assign crd_c = cur_rdata[CW-1:0];

	always_comb begin
		pg_in    = (int'(page) >= PAGES) ? PGW'(PAGES - 1) : PGW'(page);
		row_in   = (int'(row) >= ROWS) ? RW'(ROWS - 1) : RW'(row);
		top_in   = (int'(top) >= ROWS) ? RW'(ROWS - 1) : RW'(top);
		bot_in   = (int'(bottom) >= ROWS) ? RW'(ROWS - 1) : RW'(bottom);
		col_in   = (int'(column) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(column);
		left_in  = (int'(left) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(left);
		right_in = (int'(right) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(right);
	end

	assign height    = XW'(sc_b_q) - XW'(sc_t_q) + XW'(1);
	assign win_empty = (sc_t_q > sc_b_q) || (sc_l_q > sc_r_q);
	assign rowsel    = sc_job_q ? (sc_up_q ? sc_t_q : sc_b_q) : cur_r_q;
	assign blank     = sc_up_q ? ((XW'(sr_q) + XW'(n_q)) > XW'(sc_b_q))
	                           : (XW'(sr_q) < (XW'(sc_t_q) + XW'(n_q)));
	assign col_end   = (sc_c_q == sc_r_q);
	assign row_end   = (sr_q == (sc_up_q ? sc_b_q : sc_t_q));

	tcce_ram #(.WIDTH(16), .DEPTH(CELLS)) u_cells (
		.clk   (clk),
		.we    (cell_we),
		.addr  (cell_addr),
		.wdata (cell_wdata),
		.rdata (cell_rdata)
	);

	tcce_ram #(.WIDTH(RW + CW), .DEPTH(PAGES)) u_cursors (
		.clk   (clk),
		.we    (cur_we),
		.addr  (cur_addr),
		.wdata (cur_wdata),
		.rdata (cur_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcce_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cell_we    = 1'b0;
		cell_addr  = addr_q;
		cell_wdata = {sc_attr_q, tcce_pkg::CH_SPACE};
		cur_we     = 1'b0;
		cur_addr   = pg_q;
		cur_wdata  = {cur_r_q, cur_c_q};
		case (state_q)
			tcce_pkg::ST_CLEAR: begin
				cell_we    = 1'b1;
				cell_addr  = clr_q;
				cell_wdata = tcce_pkg::BLANK_CELL;
				cur_we     = (32'(clr_q) < PAGES);
				cur_addr   = PGW'(clr_q);
				cur_wdata  = '0;
				if (32'(clr_q) == CELLS - 1) begin
					state_d = tcce_pkg::ST_IDLE;
				end
			end
			tcce_pkg::ST_IDLE: begin
				cur_addr = pg_in;
				if (start) begin
					state_d = tcce_pkg::ST_CUR;
				end
			end
			tcce_pkg::ST_CUR: begin
				state_d = tcce_pkg::ST_CURWR;
				case (mode_q)
					tcce_pkg::MODE_SCROLL_UP, tcce_pkg::MODE_SCROLL_DOWN: begin
						if (!win_empty) begin
							state_d = tcce_pkg::ST_PB;
						end
					end
					tcce_pkg::MODE_READ_CELL, tcce_pkg::MODE_REPEAT: begin
						state_d = tcce_pkg::ST_PB;
					end
					tcce_pkg::MODE_TELETYPE: begin
						if (ch_q == tcce_pkg::CH_LF) begin
							if (int'(crd_r) == ROWS - 1) begin
								state_d = tcce_pkg::ST_PB;
							end
						end else if (ch_q != tcce_pkg::CH_BEL && ch_q != tcce_pkg::CH_BS
								&& ch_q != tcce_pkg::CH_CR) begin
							state_d = tcce_pkg::ST_PB;
						end
					end
					default: begin
						state_d = tcce_pkg::ST_CURWR;
					end
				endcase
			end
			tcce_pkg::ST_PB: begin
				state_d = tcce_pkg::ST_AB;
			end
			tcce_pkg::ST_AB: begin
				if (sc_job_q) begin
					state_d = tcce_pkg::ST_SC_RD;
				end else begin
					case (mode_q)
						tcce_pkg::MODE_READ_CELL: state_d = tcce_pkg::ST_RC_RD;
						tcce_pkg::MODE_REPEAT:    state_d = tcce_pkg::ST_RW_RD;
						default:                  state_d = tcce_pkg::ST_TT_RD;
					endcase
				end
			end
			tcce_pkg::ST_RC_RD: begin
				state_d = tcce_pkg::ST_RC_GOT;
			end
			tcce_pkg::ST_RC_GOT: begin
				state_d = tcce_pkg::ST_CURWR;
			end
			tcce_pkg::ST_TT_RD: begin
				state_d = tcce_pkg::ST_TT_WR;
			end
			tcce_pkg::ST_TT_WR: begin
				cell_we    = 1'b1;
				cell_wdata = {cell_rdata[15:8], ch_q};
				if (int'(cur_c_q) == COLUMNS - 1 && int'(cur_r_q) == ROWS - 1) begin
					state_d = tcce_pkg::ST_PB;
				end else begin
					state_d = tcce_pkg::ST_CURWR;
				end
			end
			tcce_pkg::ST_RW_RD: begin
				if (rem_q == '0) begin
					state_d = tcce_pkg::ST_CURWR;
				end else begin
					state_d = tcce_pkg::ST_RW_WR;
				end
			end
			tcce_pkg::ST_RW_WR: begin
				cell_we    = 1'b1;
				cell_wdata = {wattr_q ? attr_q : cell_rdata[15:8], ch_q};
				if (32'(pos_q) == CPP - 1) begin
					state_d = tcce_pkg::ST_CURWR;
				end else begin
					state_d = tcce_pkg::ST_RW_RD;
				end
			end
			tcce_pkg::ST_SC_RD: begin
				cell_addr = sbase_q + AW'(sc_c_q);
				state_d   = tcce_pkg::ST_SC_WR;
			end
			tcce_pkg::ST_SC_WR: begin
				cell_we    = 1'b1;
				cell_addr  = dbase_q + AW'(sc_c_q);
				cell_wdata = blank ? {sc_attr_q, tcce_pkg::CH_SPACE} : cell_rdata;
				if (col_end && row_end) begin
					state_d = tcce_pkg::ST_CURWR;
				end else begin
					state_d = tcce_pkg::ST_SC_RD;
				end
			end
			tcce_pkg::ST_CURWR: begin
				cur_we  = 1'b1;
				state_d = tcce_pkg::ST_ACTRD;
			end
			tcce_pkg::ST_ACTRD: begin
				cur_addr = shown_q;
				state_d  = tcce_pkg::ST_ACT;
			end
			tcce_pkg::ST_ACT: begin
				cur_addr = shown_q;
				state_d  = tcce_pkg::ST_IDLE;
			end
			default: begin
				state_d = tcce_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			shown_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == tcce_pkg::ST_ACT);
			if (state_q == tcce_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == tcce_pkg::ST_CUR && mode_q == tcce_pkg::MODE_SELECT_PAGE) begin
				shown_q <= pg_q;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			tcce_pkg::ST_IDLE: begin
				mode_q    <= mode;
				pg_q      <= pg_in;
				row_q     <= row_in;
				col_q     <= col_in;
				ch_q      <= character;
				attr_q    <= attribute;
				rem_q     <= count;
				wattr_q   <= write_attribute;
				sc_t_q    <= top_in;
				sc_b_q    <= bot_in;
				sc_l_q    <= left_in;
				sc_r_q    <= right_in;
				sc_attr_q <= attribute;
				sc_up_q   <= (mode == tcce_pkg::MODE_SCROLL_UP);
				sc_job_q  <= (mode == tcce_pkg::MODE_SCROLL_UP)
				          || (mode == tcce_pkg::MODE_SCROLL_DOWN);
				sp_q      <= (mode == tcce_pkg::MODE_SCROLL_UP
				          || mode == tcce_pkg::MODE_SCROLL_DOWN) ? shown_q : pg_in;
				rdch_q    <= '0;
				rdattr_q  <= '0;
			end
			tcce_pkg::ST_CUR: begin
				cur_r_q <= crd_r;
				cur_c_q <= crd_c;
				if ((rem_q == '0) || (rem_q >= 16'(height))) begin
					n_q <= HW'(height);
				end else begin
					n_q <= HW'(rem_q);
				end
				case (mode_q)
					tcce_pkg::MODE_SET_CURSOR: begin
						cur_r_q <= row_q;
						cur_c_q <= col_q;
					end
					tcce_pkg::MODE_TELETYPE: begin
						if (ch_q == tcce_pkg::CH_BS) begin
							if (crd_c != '0) begin
								cur_c_q <= crd_c - CW'(1);
							end
						end else if (ch_q == tcce_pkg::CH_CR) begin
							cur_c_q <= '0;
						end else if (ch_q == tcce_pkg::CH_LF) begin
							if (int'(crd_r) == ROWS - 1) begin
								sc_t_q    <= '0;
								sc_b_q    <= RW'(ROWS - 1);
								sc_l_q    <= '0;
								sc_r_q    <= CW'(COLUMNS - 1);
								n_q       <= HW'(1);
								sc_attr_q <= '0;
								sc_up_q   <= 1'b1;
								sc_job_q  <= 1'b1;
							end else begin
								cur_r_q <= crd_r + RW'(1);
							end
						end
					end
					default: begin
						cur_r_q <= crd_r;
					end
				endcase
			end
			tcce_pkg::ST_PB: begin
				pbase_q  <= AW'(sp_q * CPP);
				rowoff_q <= AW'(rowsel * COLUMNS);
				noff_q   <= AW'(n_q * COLUMNS);
			end
			tcce_pkg::ST_AB: begin
				addr_q  <= pbase_q + rowoff_q + AW'(cur_c_q);
				pos_q   <= PSW'(rowoff_q + AW'(cur_c_q));
				dbase_q <= pbase_q + rowoff_q;
				sbase_q <= sc_up_q ? (pbase_q + rowoff_q + noff_q)
				                   : (pbase_q + rowoff_q - noff_q);
				sr_q    <= rowsel;
				sc_c_q  <= sc_l_q;
			end
			tcce_pkg::ST_RC_GOT: begin
				rdch_q   <= cell_rdata[7:0];
				rdattr_q <= cell_rdata[15:8];
			end
			tcce_pkg::ST_TT_WR: begin
				if (int'(cur_c_q) == COLUMNS - 1 && int'(cur_r_q) == ROWS - 1) begin
					cur_c_q   <= '0;
					sc_t_q    <= '0;
					sc_b_q    <= RW'(ROWS - 1);
					sc_l_q    <= '0;
					sc_r_q    <= CW'(COLUMNS - 1);
					n_q       <= HW'(1);
					sc_attr_q <= '0;
					sc_up_q   <= 1'b1;
					sc_job_q  <= 1'b1;
				end else if (int'(cur_c_q) == COLUMNS - 1) begin
					cur_c_q <= '0;
					cur_r_q <= cur_r_q + RW'(1);
				end else begin
					cur_c_q <= cur_c_q + CW'(1);
				end
			end
			tcce_pkg::ST_RW_WR: begin
				rem_q  <= rem_q - 16'd1;
				pos_q  <= pos_q + PSW'(1);
				addr_q <= addr_q + AW'(1);
			end
			tcce_pkg::ST_SC_WR: begin
				if (col_end) begin
					sc_c_q <= sc_l_q;
					if (sc_up_q) begin
						sr_q    <= sr_q + RW'(1);
						dbase_q <= dbase_q + AW'(COLUMNS);
						sbase_q <= sbase_q + AW'(COLUMNS);
					end else begin
						sr_q    <= sr_q - RW'(1);
						dbase_q <= dbase_q - AW'(COLUMNS);
						sbase_q <= sbase_q - AW'(COLUMNS);
					end
				end else begin
					sc_c_q <= sc_c_q + CW'(1);
				end
			end
			tcce_pkg::ST_ACT: begin
				o_row_q  <= 5'(cur_r_q);
				o_col_q  <= 7'(cur_c_q);
				o_ch_q   <= rdch_q;
				o_attr_q <= rdattr_q;
				o_page_q <= 3'(shown_q);
				o_arow_q <= 5'(crd_r);
				o_acol_q <= 7'(crd_c);
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign busy           = (state_q != tcce_pkg::ST_IDLE);
	assign done           = done_q;
	assign cursor_row     = o_row_q;
	assign cursor_column  = o_col_q;
	assign read_character = o_ch_q;
	assign read_attribute = o_attr_q;
	assign active_page    = o_page_q;
	assign active_row     = o_arow_q;
	assign active_column  = o_acol_q;

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result word while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request word not taken");
	a_cell_range: assert property (@(posedge clk) disable iff (!arst_n)
		cell_we |-> (32'(cell_addr) < CELLS)) else $error("cell write out of range");
	a_shown_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(shown_q) < PAGES) else $error("shown page out of range");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result word repeated");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

	localparam int PAGES = 8;
	localparam int ROWS = 25;
	localparam int COLUMNS = 80;
	localparam int CELLS = ROWS * COLUMNS;
	localparam int LIMIT = 6000000;
	localparam int RANDOM_WORDS = 290;

	typedef struct packed {
		logic [2:0]  mode;
		logic [2:0]  page;
		logic [4:0]  row;
		logic [6:0]  column;
		logic [7:0]  character;
		logic [7:0]  attribute;
		logic [15:0] count;
		logic        write_attribute;
		logic [4:0]  top;
		logic [6:0]  left;
		logic [4:0]  bottom;
		logic [6:0]  right;
	} console_request_t;

	typedef struct packed {
		logic [4:0] cursor_row;
		logic [6:0] cursor_column;
		logic [7:0] read_character;
		logic [7:0] read_attribute;
		logic [2:0] active_page;
		logic [4:0] active_row;
		logic [6:0] active_column;
	} console_view_t;

	class console_scoreboard;
		bit [15:0] cells[PAGES * CELLS];
		int cur_row[PAGES];
		int cur_col[PAGES];
		int shown;
		console_view_t pending[$];
		int fails;

		function new();
			foreach (cells[i]) cells[i] = tcce_pkg::BLANK_CELL;
			foreach (cur_row[i]) begin
				cur_row[i] = 0;
				cur_col[i] = 0;
			end
			shown = 0;
			fails = 0;
		endfunction

		function int clip(int v, int lim);
			return (v >= lim) ? lim - 1 : v;
		endfunction

		function int at(int pg, int r, int c);
			return (pg * ROWS + r) * COLUMNS + c;
		endfunction

		function void blank(int pg, int r, int l, int rt, bit [7:0] a);
			for (int c = l; c <= rt; c++) cells[at(pg, r, c)] = {a, tcce_pkg::CH_SPACE};
		endfunction

		function void scroll(int pg, bit up, int n, bit [7:0] a, int t, int l, int b, int rt);
			if (t > b || l > rt) return;
			if (n == 0 || n >= b - t + 1) begin
				for (int r = t; r <= b; r++) blank(pg, r, l, rt, a);
				return;
			end
			if (up) begin
				for (int r = t; r + n <= b; r++)
					for (int c = l; c <= rt; c++) cells[at(pg, r, c)] = cells[at(pg, r + n, c)];
				for (int k = 0; k < n; k++) blank(pg, b - k, l, rt, a);
			end else begin
				for (int r = b; r >= t + n; r--)
					for (int c = l; c <= rt; c++) cells[at(pg, r, c)] = cells[at(pg, r - n, c)];
				for (int k = 0; k < n; k++) blank(pg, t + k, l, rt, a);
			end
		endfunction

		function void teletype(int pg, bit [7:0] ch);
			int r;
			int c;
			int i;
			r = cur_row[pg];
			c = cur_col[pg];
			if (ch == tcce_pkg::CH_BEL) begin
			end else if (ch == tcce_pkg::CH_BS) begin
				if (c != 0) c--;
			end else if (ch == tcce_pkg::CH_LF) begin
				if (r == ROWS - 1) scroll(pg, 1, 1, 8'h00, 0, 0, ROWS - 1, COLUMNS - 1);
				else r++;
			end else if (ch == tcce_pkg::CH_CR) begin
				c = 0;
			end else begin
				i = at(pg, r, c);
				cells[i][7:0] = ch;
				if (c == COLUMNS - 1 && r == ROWS - 1) begin
					c = 0;
					scroll(pg, 1, 1, 8'h00, 0, 0, ROWS - 1, COLUMNS - 1);
				end else if (c == COLUMNS - 1) begin
					c = 0;
					r++;
				end else begin
					c++;
				end
			end
			cur_row[pg] = r;
			cur_col[pg] = c;
		endfunction

		function void note(console_request_t q);
			int pg;
			int pos;
			bit [15:0] v;
			console_view_t e;
			pg = clip(int'(q.page), PAGES);
			e = '0;
			case (q.mode)
				tcce_pkg::MODE_SET_CURSOR: begin
					cur_row[pg] = clip(int'(q.row), ROWS);
					cur_col[pg] = clip(int'(q.column), COLUMNS);
				end
				tcce_pkg::MODE_READ_CURSOR: ;
				tcce_pkg::MODE_SELECT_PAGE: shown = pg;
				tcce_pkg::MODE_SCROLL_UP, tcce_pkg::MODE_SCROLL_DOWN:
					scroll(shown, q.mode == tcce_pkg::MODE_SCROLL_UP, int'(q.count),
						q.attribute,
						clip(int'(q.top), ROWS), clip(int'(q.left), COLUMNS),
						clip(int'(q.bottom), ROWS), clip(int'(q.right), COLUMNS));
				tcce_pkg::MODE_READ_CELL: begin
					v = cells[at(pg, cur_row[pg], cur_col[pg])];
					e.read_character = v[7:0];
					e.read_attribute = v[15:8];
				end
				tcce_pkg::MODE_REPEAT: begin
					pos = cur_row[pg] * COLUMNS + cur_col[pg];
					for (int k = 0; k < int'(q.count) && pos < CELLS; k++, pos++) begin
						v = cells[pg * CELLS + pos];
						if (q.write_attribute) v[15:8] = q.attribute;
						v[7:0] = q.character;
						cells[pg * CELLS + pos] = v;
					end
				end
				default: teletype(pg, q.character);
			endcase
			e.cursor_row = 5'(cur_row[pg]);
			e.cursor_column = 7'(cur_col[pg]);
			e.active_page = 3'(shown);
			e.active_row = 5'(cur_row[shown]);
			e.active_column = 7'(cur_col[shown]);
			pending.push_back(e);
		endfunction

		function void check(console_view_t got);
			console_view_t e;
			if (pending.size() == 0) begin
				$error("result word with nothing pending");
				fails++;
				return;
			end
			e = pending.pop_front();
			if (got.cursor_row !== e.cursor_row) begin
				$error("cursor_row exp %0d got %0d", e.cursor_row, got.cursor_row);
				fails++;
			end
			if (got.cursor_column !== e.cursor_column) begin
				$error("cursor_column exp %0d got %0d", e.cursor_column, got.cursor_column);
				fails++;
			end
			if (got.read_character !== e.read_character) begin
				$error("read_character exp %0h got %0h", e.read_character, got.read_character);
				fails++;
			end
			if (got.read_attribute !== e.read_attribute) begin
				$error("read_attribute exp %0h got %0h", e.read_attribute, got.read_attribute);
				fails++;
			end
			if (got.active_page !== e.active_page) begin
				$error("active_page exp %0d got %0d", e.active_page, got.active_page);
				fails++;
			end
			if (got.active_row !== e.active_row) begin
				$error("active_row exp %0d got %0d", e.active_row, got.active_row);
				fails++;
			end
			if (got.active_column !== e.active_column) begin
				$error("active_column exp %0d got %0d", e.active_column, got.active_column);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	logic [2:0] mode;
	logic [2:0] page;
	logic [4:0] row;
	logic [6:0] column;
	logic [7:0] character;
	logic [7:0] attribute;
	logic [15:0] count;
	logic write_attribute;
	logic [4:0] top;
	logic [6:0] left;
	logic [4:0] bottom;
	logic [6:0] right;
	logic [4:0] cursor_row;
	logic [6:0] cursor_column;
	logic [7:0] read_character;
	logic [7:0] read_attribute;
	logic [2:0] active_page;
	logic [4:0] active_row;
	logic [6:0] active_column;

	console_scoreboard sb;
	int cycles;

	text_console_cell_engine #(.PAGES(PAGES), .ROWS(ROWS), .COLUMNS(COLUMNS)) dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && done)
			sb.check({cursor_row, cursor_column, read_character, read_attribute,
				active_page, active_row, active_column});

	// hold start and load the word, return once it is taken
	task automatic send_word(console_request_t q);
		mode <= q.mode;
		page <= q.page;
		row <= q.row;
		column <= q.column;
		character <= q.character;
		attribute <= q.attribute;
		count <= q.count;
		write_attribute <= q.write_attribute;
		top <= q.top;
		left <= q.left;
		bottom <= q.bottom;
		right <= q.right;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note(q);
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic console_request_t make_word(logic [2:0] m, logic [2:0] p,
		logic [4:0] r, logic [6:0] c, logic [7:0] ch, logic [7:0] a, logic [15:0] n,
		logic wa, logic [4:0] t, logic [6:0] l, logic [4:0] b, logic [6:0] rt);
		console_request_t q;
		q = '{m, p, r, c, ch, a, n, wa, t, l, b, rt};
		return q;
	endfunction

	function automatic console_request_t random_word();
		console_request_t q;
		int pick;
		q = console_request_t'(75'({$urandom, $urandom, $urandom}));
		pick = $urandom_range(0, 99);
		if (pick < 35) q.mode = tcce_pkg::MODE_TELETYPE;
		else if (pick < 50) q.mode = tcce_pkg::MODE_SET_CURSOR;
		else if (pick < 58) q.mode = tcce_pkg::MODE_READ_CELL;
		else if (pick < 68) q.mode = tcce_pkg::MODE_REPEAT;
		else if (pick < 76) q.mode = tcce_pkg::MODE_SCROLL_UP;
		else if (pick < 84) q.mode = tcce_pkg::MODE_SCROLL_DOWN;
		else if (pick < 92) q.mode = tcce_pkg::MODE_SELECT_PAGE;
		else q.mode = tcce_pkg::MODE_READ_CURSOR;
		if ($urandom_range(0, 3) != 0) q.page = 3'($urandom_range(0, 2));
		if (q.mode == tcce_pkg::MODE_SET_CURSOR && $urandom_range(0, 1)) begin
			q.row = 5'($urandom_range(22, 31));
			q.column = 7'($urandom_range(70, 127));
		end
		if (q.mode == tcce_pkg::MODE_TELETYPE && $urandom_range(0, 2) == 0)
			case ($urandom_range(0, 3))
				0: q.character = tcce_pkg::CH_BEL;
				1: q.character = tcce_pkg::CH_BS;
				2: q.character = tcce_pkg::CH_LF;
				default: q.character = tcce_pkg::CH_CR;
			endcase
		if (q.mode == tcce_pkg::MODE_REPEAT && $urandom_range(0, 15) != 0)
			q.count = 16'($urandom_range(0, 40));
		if ((q.mode == tcce_pkg::MODE_SCROLL_UP || q.mode == tcce_pkg::MODE_SCROLL_DOWN)
			&& $urandom_range(0, 4) != 0) begin
			q.count = 16'($urandom_range(0, 5));
			q.top = 5'($urandom_range(0, 24));
			q.bottom = 5'(int'(q.top) + $urandom_range(0, 4));
			q.left = 7'($urandom_range(0, 79));
			q.right = 7'(int'(q.left) + $urandom_range(0, 15));
		end
		return q;
	endfunction

	initial begin
		console_request_t q;
		int burst;
		sb = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		mode <= '0;
		page <= '0;
		row <= '0;
		column <= '0;
		character <= '0;
		attribute <= '0;
		count <= '0;
		write_attribute <= 1'b0;
		top <= '0;
		left <= '0;
		bottom <= '0;
		right <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(make_word(tcce_pkg::MODE_READ_CELL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_SET_CURSOR, 7, 31, 127, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_READ_CURSOR, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_REPEAT, 7, 0, 0, 8'hff, 8'hff, 16'hffff, 1,
			0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_READ_CELL, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_TELETYPE, 7, 0, 0, 8'h41, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_SELECT_PAGE, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_SCROLL_DOWN, 0, 0, 0, 0, 8'h71, 2, 0,
			0, 0, 31, 127));
		send_word(make_word(tcce_pkg::MODE_SCROLL_UP, 0, 0, 0, 0, 8'h1e, 1, 0,
			20, 10, 24, 40));
		send_word(make_word(tcce_pkg::MODE_SCROLL_UP, 0, 0, 0, 0, 8'h22, 0, 0, 3, 3, 5, 9));
		send_word(make_word(tcce_pkg::MODE_SCROLL_DOWN, 0, 0, 0, 0, 8'h33, 16'hffff, 0,
			5, 5, 6, 6));
		send_word(make_word(tcce_pkg::MODE_SCROLL_UP, 0, 0, 0, 0, 8'h44, 1, 0, 9, 0, 8, 79));
		send_word(make_word(tcce_pkg::MODE_SCROLL_UP, 0, 0, 0, 0, 8'h44, 1, 0, 0, 9, 24, 8));
		send_word(make_word(tcce_pkg::MODE_SET_CURSOR, 1, 24, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_TELETYPE, 1, 0, 0, tcce_pkg::CH_BS, 0, 0, 0,
			0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_REPEAT, 1, 0, 0, 8'h5a, 8'h00, 3, 0, 0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_TELETYPE, 1, 0, 0, 8'h42, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_TELETYPE, 1, 0, 0, tcce_pkg::CH_BS, 0, 0, 0,
			0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_TELETYPE, 1, 0, 0, tcce_pkg::CH_BEL, 0, 0, 0,
			0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_TELETYPE, 1, 0, 0, tcce_pkg::CH_LF, 0, 0, 0,
			0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_TELETYPE, 1, 0, 0, tcce_pkg::CH_CR, 0, 0, 0,
			0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_SET_CURSOR, 1, 3, 79, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_TELETYPE, 1, 0, 0, 8'h00, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(tcce_pkg::MODE_READ_CELL, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

		for (int i = 0; i < RANDOM_WORDS; i += burst) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst; k++) begin
				q = random_word();
				send_word(q);
			end
			pause($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20));
		end
		start <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
